// ----- hdl/aabbfc_pkg.sv -----
// ----------------------------------------------------------------------------
// aabbfc_pkg
// Types and constants shared by the box-versus-frustum classifier.
// ----------------------------------------------------------------------------
package aabbfc_pkg;

	localparam int REG_COUNT   = 6;
	localparam int REG_IDX_W   = 3;
	localparam int PLANE_W     = 64;
	localparam int COORD_W     = 16;
	localparam int EXT_W       = 15;
	localparam int SUM_W       = 35;
	localparam int FRAC_BITS   = 14;
	localparam int IN_TDATA_W  = 96;
	localparam int OUT_TDATA_W = 8;

	typedef enum logic [1:0] {
		VIS_INSIDE  = 2'd0,
		VIS_PARTIAL = 2'd1,
		VIS_OUTSIDE = 2'd2
	} vis_t;

	typedef struct packed {
		logic        [EXT_W-1:0]   ext_z;
		logic        [EXT_W-1:0]   ext_y;
		logic        [EXT_W-1:0]   ext_x;
		logic signed [COORD_W-1:0] center_z;
		logic signed [COORD_W-1:0] center_y;
		logic signed [COORD_W-1:0] center_x;
	} box_t;

	typedef struct packed {
		logic outside;
		logic partial;
	} plane_flags_t;

endpackage

// ----- hdl/aabbfc_plane_regs.sv -----
// ----------------------------------------------------------------------------
// aabbfc_plane_regs
// Holds the packed plane registers written through the configuration port.
// ----------------------------------------------------------------------------
module aabbfc_plane_regs import aabbfc_pkg::*; #(
	parameter int STORED = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [PLANE_W-1:0]   cfg_data,
	output logic [PLANE_W-1:0]   planes [STORED]
);

	logic [PLANE_W-1:0] plane_q [STORED];

	for (genvar i = 0; i < STORED; i++) begin : g_reg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				plane_q[i] <= '0;
			end else if (cfg_we && cfg_index == REG_IDX_W'(i)) begin
				plane_q[i] <= cfg_data;
			end
		end
		assign planes[i] = plane_q[i];
	end

endmodule

// ----- hdl/aabbfc_plane_test.sv -----
// ----------------------------------------------------------------------------
// aabbfc_plane_test
// Tests one box against one plane: projected radius and signed center
// distance in units of 2^-14, then the sign of distance plus and minus radius.
// ----------------------------------------------------------------------------
module aabbfc_plane_test import aabbfc_pkg::*; (
	input  box_t               box,
	input  logic [PLANE_W-1:0] plane,
	output plane_flags_t       flags
);

	logic signed [15:0]      nx, ny, nz, dd;
	logic        [15:0]      anx, any, anz;
	logic        [30:0]      px, py, pz;
	logic signed [31:0]      qx, qy, qz;
	logic signed [29:0]      dq;
	logic signed [SUM_W-1:0] rad, sdist, hi, lo;

	always_comb begin
		nx  = signed'(plane[15:0]);
		ny  = signed'(plane[31:16]);
		nz  = signed'(plane[47:32]);
		dd  = signed'(plane[63:48]);
		// Two's complement magnitude; the most negative code maps to 2.0.
		anx = nx[15] ? (~plane[15:0] + 16'd1) : plane[15:0];
		any = ny[15] ? (~plane[31:16] + 16'd1) : plane[31:16];
		anz = nz[15] ? (~plane[47:32] + 16'd1) : plane[47:32];
		px  = 31'(box.ext_x) * 31'(anx);
		py  = 31'(box.ext_y) * 31'(any);
		pz  = 31'(box.ext_z) * 31'(anz);
		qx  = 32'(box.center_x) * 32'(nx);
		qy  = 32'(box.center_y) * 32'(ny);
		qz  = 32'(box.center_z) * 32'(nz);
		dq  = signed'({dd, {FRAC_BITS{1'b0}}});
		rad = signed'(SUM_W'(px) + SUM_W'(py) + SUM_W'(pz));
		sdist = SUM_W'(qx) + SUM_W'(qy) + SUM_W'(qz) + SUM_W'(dq);
		hi  = sdist + rad;
		lo  = sdist - rad;
		flags.outside = hi[SUM_W-1];
		flags.partial = lo[SUM_W-1];
	end

endmodule

// ----- hdl/aabb_frustum_classify.sv -----
// ----------------------------------------------------------------------------
// aabb_frustum_classify
// Classifies an axis-aligned box, given as center and half-extent, against
// the frustum planes as inside, partial or outside.
//
//   Port group   Direction  Payload
//   s_axis_*     in         one box per transfer
//   m_axis_*     out        one classification per box
//   cfg_*        in         plane register writes, no read-back
//
// Each box passes through the input register and then the result register,
// and one box is taken per cycle while the result side is not stalled.
// The per-plane multiply and add lanes run in parallel, combinationally,
// between the two registers.
// Reset clears the plane registers to zero and empties both registers.
// A stalled result holds; the input side keeps taking boxes while the
// input register can move forward.
// ----------------------------------------------------------------------------
module aabb_frustum_classify import aabbfc_pkg::*; #(
	parameter int PLANE_COUNT = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// center_x[15:0], center_y[31:16], center_z[47:32],
	// extent_x[62:48], extent_y[77:63], extent_z[92:78], zero pad
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// visibility[1:0], visible[2], zero pad
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_we,
	input  logic [REG_IDX_W-1:0]   cfg_index,
	input  logic [PLANE_W-1:0]     cfg_data
);

	localparam int STORED = (PLANE_COUNT < REG_COUNT) ? PLANE_COUNT : REG_COUNT;

	logic [PLANE_W-1:0] planes [STORED];
	plane_flags_t       flags [PLANE_COUNT];
	logic [PLANE_COUNT-1:0] outside_vec, partial_vec;

	box_t box_s1;
	logic valid_s1;
	logic valid_s2;
	vis_t vis_s2;
	logic visible_s2;
	logic adv_s2;
	logic adv_s1;
	vis_t vis_next;

	aabbfc_plane_regs #(
		.STORED(STORED)
	) u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.planes   (planes)
	);

	for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_lane
		logic [PLANE_W-1:0] plane;
		if (i < STORED) begin : g_reg
			assign plane = planes[i];
		end else begin : g_zero
			assign plane = '0;
		end
		aabbfc_plane_test u_test (
			.box  (box_s1),
			.plane(plane),
			.flags(flags[i])
		);
		assign outside_vec[i] = flags[i].outside;
		assign partial_vec[i] = flags[i].partial;
	end

	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = !valid_s1 || adv_s2;
	assign s_axis_tready = adv_s1;

	always_comb begin
		priority if (|outside_vec) begin
			vis_next = VIS_OUTSIDE;
		end else if (|partial_vec) begin
			vis_next = VIS_PARTIAL;
		end else begin
			vis_next = VIS_INSIDE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) begin
			box_s1.center_x <= signed'(s_axis_tdata[15:0]);
			box_s1.center_y <= signed'(s_axis_tdata[31:16]);
			box_s1.center_z <= signed'(s_axis_tdata[47:32]);
			box_s1.ext_x    <= s_axis_tdata[62:48];
			box_s1.ext_y    <= s_axis_tdata[77:63];
			box_s1.ext_z    <= s_axis_tdata[92:78];
		end
		if (adv_s2 && valid_s1) begin
			vis_s2     <= vis_next;
			visible_s2 <= !(|outside_vec);
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {5'd0, visible_s2, vis_s2};

	a_vis_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (vis_s2 == VIS_INSIDE || vis_s2 == VIS_PARTIAL ||
			vis_s2 == VIS_OUTSIDE))
		else $error("result carries an unused visibility code");

	a_visible_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (visible_s2 == (vis_s2 != VIS_OUTSIDE)))
		else $error("visible flag disagrees with visibility");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> m_axis_tvalid)
		else $error("box left the input register without a result");

	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while the output side was ready");

endmodule

// ----- tb/sv/aabbfc_check.sv -----
// ----------------------------------------------------------------------------
// aabbfc_check
// Watches the box, result and plane-write channels of the classifier. It
// keeps its own copy of the plane registers, works out the class of every
// accepted box, and compares each result transfer with the oldest class
// still outstanding. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module aabbfc_check import aabbfc_pkg::*; #(
	parameter int PLANE_COUNT = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_we,
	input  logic [REG_IDX_W-1:0]   cfg_index,
	input  logic [PLANE_W-1:0]     cfg_data,
	output int                     errors,
	output int                     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [PLANE_W-1:0] plane_regs [REG_COUNT];
	vis_t               pending_classes [$];

	initial begin
		errors = 0;
		pending = 0;
	end

	task automatic report_mismatch(input string msg);
		if (errors < 100) begin
			$display("%0t ns  mismatch: %s", $realtime, msg);
		end
		errors++;
	endtask

	function automatic longint mag(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic vis_t classify_box(input box_t b);
		longint             cx, cy, cz, ex, ey, ez;
		longint             nx, ny, nz, dd, rad, sdist;
		logic [PLANE_W-1:0] p;
		bit                 outside, partial;
		cx = $signed(b.center_x);
		cy = $signed(b.center_y);
		cz = $signed(b.center_z);
		ex = b.ext_x;
		ey = b.ext_y;
		ez = b.ext_z;
		outside = 1'b0;
		partial = 1'b0;
		for (int i = 0; i < PLANE_COUNT && !outside; i++) begin
			// Slots past the last register act as the all-zero plane.
			p = (i < REG_COUNT) ? plane_regs[i] : '0;
			nx = $signed(p[15:0]);
			ny = $signed(p[31:16]);
			nz = $signed(p[47:32]);
			dd = $signed(p[63:48]);
			rad = ex * mag(nx) + ey * mag(ny) + ez * mag(nz);
			sdist = nx * cx + ny * cy + nz * cz + (dd <<< FRAC_BITS);
			if (sdist + rad < 0) begin
				outside = 1'b1;
			end else if (sdist - rad < 0) begin
				partial = 1'b1;
			end
		end
		if (outside) begin
			return VIS_OUTSIDE;
		end
		if (partial) begin
			return VIS_PARTIAL;
		end
		return VIS_INSIDE;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		vis_t want;
		if (!arst_n) begin
			foreach (plane_regs[i]) begin
				plane_regs[i] = '0;
			end
			pending_classes.delete();
		end else begin
			if (cfg_we && cfg_index < REG_COUNT) begin
				plane_regs[cfg_index] = cfg_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				pending_classes.push_back(classify_box(box_t'(s_axis_tdata[$bits(box_t)-1:0])));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_classes.size() == 0) begin
					report_mismatch("result transfer with no box outstanding");
				end else begin
					want = pending_classes.pop_front();
					if (m_axis_tdata[1:0] != want) begin
						report_mismatch($sformatf("visibility got %0d, expected %0d",
							m_axis_tdata[1:0], want));
					end
					if (m_axis_tdata[2] != (want != VIS_OUTSIDE)) begin
						report_mismatch($sformatf("visible got %0d, expected %0d",
							m_axis_tdata[2], want != VIS_OUTSIDE));
					end
				end
			end
		end
		pending = pending_classes.size();
	end

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Top of the box-versus-frustum classifier testbench. It loads several plane
// sets (reset zeros, an axis-aligned cube, extreme and random encodings),
// sends directed boxes on and around the plane boundaries and then random
// boxes, with random gaps on the box side and stalls on the result side.
// The checker instance predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
	import aabbfc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PLANE_COUNT = 6;
	localparam int PLANE_LEFT   = 0;
	localparam int PLANE_RIGHT  = 1;
	localparam int PLANE_BOTTOM = 2;
	localparam int PLANE_TOP    = 3;
	localparam int PLANE_NEAR   = 4;
	localparam int PLANE_FAR    = 5;
	localparam int Q_ONE        = 1 << FRAC_BITS;
	localparam int CUBE_HALF    = 1000;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int BOX_NEAR     = 0;
	localparam int BOX_FULL     = 1;
	localparam int BOX_EXTREME  = 2;
	localparam int BOX_ANY      = 3;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_we;
	logic [REG_IDX_W-1:0]   cfg_index;
	logic [PLANE_W-1:0]     cfg_data;
	int                     errors;
	int                     pending;
	bit                     calm;
	int                     cycle_count = 0;
	logic [PLANE_W-1:0]     plane_set [REG_COUNT];

	aabb_frustum_classify #(.PLANE_COUNT(PLANE_COUNT)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	aabbfc_check #(.PLANE_COUNT(PLANE_COUNT)) check (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	function automatic logic [PLANE_W-1:0] pack_plane(input int nx, input int ny,
		input int nz, input int d);
		return {16'(d), 16'(nz), 16'(ny), 16'(nx)};
	endfunction

	function automatic box_t make_box(input int cx, input int cy, input int cz,
		input int ex, input int ey, input int ez);
		box_t b;
		b.center_x = 16'(cx);
		b.center_y = 16'(cy);
		b.center_z = 16'(cz);
		b.ext_x = 15'(ex);
		b.ext_y = 15'(ey);
		b.ext_z = 15'(ez);
		return b;
	endfunction

	function automatic int extreme_coord();
		case ($urandom_range(0, 4))
			0: return -32768;
			1: return 32767;
			2: return 0;
			3: return -1;
			default: return int'($urandom);
		endcase
	endfunction

	function automatic int extreme_extent();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 32767;
			2: return 1;
			default: return int'($urandom_range(0, 32767));
		endcase
	endfunction

	function automatic box_t rand_box(input int style);
		case (style)
			BOX_NEAR: begin
				return make_box(int'($urandom_range(0, 6000)) - 3000,
					int'($urandom_range(0, 6000)) - 3000,
					int'($urandom_range(0, 6000)) - 3000,
					$urandom_range(0, 2000), $urandom_range(0, 2000),
					$urandom_range(0, 2000));
			end
			BOX_EXTREME: begin
				return make_box(extreme_coord(), extreme_coord(), extreme_coord(),
					extreme_extent(), extreme_extent(), extreme_extent());
			end
			default: begin
				return make_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			end
		endcase
	endfunction

	task automatic send_box(input box_t b);
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_axis_tdata <= IN_TDATA_W'(b);
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic run_random(input int count, input int style);
		for (int i = 0; i < count; i++) begin
			send_box(rand_box((style == BOX_ANY) ? $urandom_range(BOX_NEAR, BOX_EXTREME) : style));
		end
	endtask

	// Stops sending and waits until every outstanding class has been
	// returned, then lets the pipeline settle.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Indexes past the last register get random data and must be ignored.
	task automatic load_planes();
		for (int i = 0; i < REG_COUNT; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_IDX_W'(i);
			cfg_data <= plane_set[i];
			@(posedge clk);
		end
		for (int i = REG_COUNT; i < (1 << REG_IDX_W); i++) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_IDX_W'(i);
			cfg_data <= {$urandom, $urandom};
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic load_cube();
		plane_set[PLANE_LEFT]   = pack_plane(Q_ONE, 0, 0, CUBE_HALF);
		plane_set[PLANE_RIGHT]  = pack_plane(-Q_ONE, 0, 0, CUBE_HALF);
		plane_set[PLANE_BOTTOM] = pack_plane(0, Q_ONE, 0, CUBE_HALF);
		plane_set[PLANE_TOP]    = pack_plane(0, -Q_ONE, 0, CUBE_HALF);
		plane_set[PLANE_NEAR]   = pack_plane(0, 0, Q_ONE, CUBE_HALF);
		plane_set[PLANE_FAR]    = pack_plane(0, 0, -Q_ONE, CUBE_HALF);
		load_planes();
	endtask

	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			if (!calm) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With the reset planes every box is inside.
		send_box(make_box(0, 0, 0, 0, 0, 0));
		send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
		send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
		send_box(make_box(-1, -1, -1, 0, 0, 0));
		run_random(50, BOX_ANY);

		// Cube of half size CUBE_HALF around the origin, boundaries included.
		drain();
		load_cube();
		send_box(make_box(0, 0, 0, 0, 0, 0));
		send_box(make_box(0, 0, 0, CUBE_HALF, CUBE_HALF, CUBE_HALF));
		send_box(make_box(0, 0, 0, CUBE_HALF + 1, 0, 0));
		send_box(make_box(-2 * CUBE_HALF, 0, 0, CUBE_HALF, 0, 0));
		send_box(make_box(-2 * CUBE_HALF, 0, 0, CUBE_HALF - 1, 0, 0));
		send_box(make_box(2 * CUBE_HALF, 0, 0, CUBE_HALF - 1, 0, 0));
		send_box(make_box(0, -2 * CUBE_HALF, 0, 0, CUBE_HALF - 1, 0));
		send_box(make_box(0, 2 * CUBE_HALF, 0, 0, CUBE_HALF - 1, 0));
		send_box(make_box(0, 0, -2 * CUBE_HALF, 0, 0, CUBE_HALF - 1));
		send_box(make_box(0, 0, 2 * CUBE_HALF, 0, 0, CUBE_HALF - 1));
		send_box(make_box(0, 0, 2 * CUBE_HALF, 0, 0, CUBE_HALF));
		send_box(make_box(-32768, 32767, 0, 32767, 32767, 32767));
		send_box(make_box(32767, -32768, -32768, 0, 0, 0));
		send_box(make_box(CUBE_HALF, -CUBE_HALF, CUBE_HALF, 0, 0, 0));
		run_random(400, BOX_NEAR);

		// Every normal component at -2.0 and the most negative offset.
		drain();
		foreach (plane_set[i]) begin
			plane_set[i] = pack_plane(-32768, -32768, -32768, -32768);
		end
		load_planes();
		send_box(make_box(-32768, -32768, -32768, 0, 0, 0));
		send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
		send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
		send_box(make_box(32767, 32767, 32767, 0, 0, 0));
		run_random(300, BOX_ANY);

		// Largest positive values mixed with -2.0 across the planes.
		drain();
		foreach (plane_set[i]) begin
			plane_set[i] = (i % 2) ? pack_plane(-32768, 32767, 32767, 32767)
				: pack_plane(32767, 32767, -32768, -32768);
		end
		load_planes();
		run_random(300, BOX_ANY);

		drain();
		foreach (plane_set[i]) begin
			plane_set[i] = '1;
		end
		load_planes();
		run_random(200, BOX_ANY);

		repeat (3) begin
			drain();
			foreach (plane_set[i]) begin
				plane_set[i] = {$urandom, $urandom};
			end
			load_planes();
			run_random(100, BOX_ANY);
			drain();
			run_random(100, BOX_ANY);
		end

		// Closing stretch at full rate on both sides.
		drain();
		load_cube();
		calm = 1'b1;
		run_random(300, BOX_NEAR);
		drain();

		if (errors == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
